### sv/tun_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants of the triangle unit normal core
// Widths of the normalized datapath, register map and the sideband tag that
// travels with each beat through the pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

   localparam int COORD_WIDTH_DEF = 24;   // default vertex coordinate width
   localparam int TINY_WIDTH      = 21;   // degeneracy threshold width
   localparam int NORM_BITS       = 31;   // normalized magnitude width
   localparam int SQ_WIDTH        = 2 * NORM_BITS;
   localparam int SUM_WIDTH       = 64;   // sum of three squares
   localparam int ROOT_WIDTH      = 32;
   localparam int SQRT_STEPS      = SUM_WIDTH / 2;
   localparam int QUO_WIDTH       = 31;   // quotient never exceeds 2^30
   localparam int DIV_STEPS       = QUO_WIDTH;
   localparam int UNIT_WIDTH      = 32;   // Q2.30 result

   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // register index, taken from the word address
   localparam logic [0:0] REG_TINY_LENGTH = 1'b0;

   // per-beat flags carried alongside the data
   typedef struct packed {
      logic       used_given;
      logic       degen;
      logic [2:0] neg;
   } tag_type;

   localparam int TAG_WIDTH = $bits(tag_type);

endpackage

### sv/tun_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_front: edge vectors, cross product and degeneracy test
// Six stages: differences, products, cross terms, source select and
// magnitude, threshold squares, length compare.
// ----------------------------------------------------------------------------
module tun_front #(
   parameter int CoordWidth = tun_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [tun_pkg::TINY_WIDTH-1:0]  tiny,
   input  logic signed [CoordWidth-1:0]    coord [12],
   output logic                            out_valid,
   output tun_pkg::tag_type                out_tag,
   output logic [2*CoordWidth:0]           out_mag [3]
);
   import tun_pkg::*;

   localparam int DW   = CoordWidth + 1;      // edge component
   localparam int PW   = 2 * DW;              // product and cross term
   localparam int MW   = 2 * CoordWidth + 1;  // magnitude
   localparam int SQW  = 2 * TINY_WIDTH;
   localparam int SUMW = SQW + 2;

   logic                       v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [DW-1:0]       u1_ff [3];
   logic signed [DW-1:0]       w1_ff [3];
   logic signed [CoordWidth-1:0] g1_ff [3], g2_ff [3], g3_ff [3];
   logic                       given1_ff, given2_ff, given3_ff, given4_ff;
   logic                       given5_ff;
   logic signed [PW-1:0]       p2_ff [6];
   logic signed [PW-1:0]       c3_ff [3];
   logic signed [PW-1:0]       src4 [3];
   logic [PW-1:0]              abs4 [3];
   logic [MW-1:0]              mag4_in [3];
   logic [2:0]                 neg4_in;
   logic                       small4_in;
   logic [MW-1:0]              mag4_ff [3], mag5_ff [3], mag6_ff [3];
   logic [2:0]                 neg4_ff, neg5_ff;
   logic                       small4_ff, small5_ff;
   logic [SQW-1:0]             sq5_ff [3];
   logic [SQW-1:0]             tsq5_ff;
   logic [SUMW-1:0]            sum6;
   tag_type                    tag6_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // stage 1: edges b-a and c-a
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u1_ff[i] <= {coord[3+i][CoordWidth-1], coord[3+i]}
                        - {coord[i][CoordWidth-1], coord[i]};
            w1_ff[i] <= {coord[6+i][CoordWidth-1], coord[6+i]}
                        - {coord[i][CoordWidth-1], coord[i]};
            g1_ff[i] <= coord[9+i];
         end
         given1_ff <= |{coord[9], coord[10], coord[11]};
      end
   end

   // stage 2: six partial products
   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff[0] <= u1_ff[1] * w1_ff[2];
         p2_ff[1] <= u1_ff[2] * w1_ff[1];
         p2_ff[2] <= u1_ff[2] * w1_ff[0];
         p2_ff[3] <= u1_ff[0] * w1_ff[2];
         p2_ff[4] <= u1_ff[0] * w1_ff[1];
         p2_ff[5] <= u1_ff[1] * w1_ff[0];
         g2_ff     <= g1_ff;
         given2_ff <= given1_ff;
      end
   end

   // stage 3: cross product terms
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            c3_ff[i] <= p2_ff[2*i] - p2_ff[2*i+1];
         g3_ff     <= g2_ff;
         given3_ff <= given2_ff;
      end
   end

   // stage 4: pick supplied or computed vector, take magnitudes
   always_comb begin
      small4_in = ~given3_ff;
      for (int i = 0; i < 3; i++) begin
         src4[i]    = given3_ff ? PW'(g3_ff[i]) : c3_ff[i];
         neg4_in[i] = src4[i][PW-1];
         abs4[i]    = neg4_in[i] ? PW'(-src4[i]) : PW'(src4[i]);
         mag4_in[i] = abs4[i][MW-1:0];
         if (mag4_in[i] > MW'(tiny))
            small4_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag4_ff   <= mag4_in;
         neg4_ff   <= neg4_in;
         small4_ff <= small4_in;
         given4_ff <= given3_ff;
      end
   end

   // stage 5: squares of the short magnitudes and of the threshold
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            sq5_ff[i] <= mag4_ff[i][TINY_WIDTH-1:0] * mag4_ff[i][TINY_WIDTH-1:0];
         tsq5_ff   <= tiny * tiny;
         mag5_ff   <= mag4_ff;
         neg5_ff   <= neg4_ff;
         small5_ff <= small4_ff;
         given5_ff <= given4_ff;
      end
   end

   // stage 6: exact length compare
   assign sum6 = SUMW'(sq5_ff[0]) + SUMW'(sq5_ff[1]) + SUMW'(sq5_ff[2]);

   always_ff @(posedge clock) begin
      if (en) begin
         mag6_ff            <= mag5_ff;
         tag6_ff.neg        <= neg5_ff;
         tag6_ff.used_given <= given5_ff;
         tag6_ff.degen      <= small5_ff && (sum6 <= SUMW'(tsq5_ff));
      end
   end

   assign out_valid = v6_ff;
   assign out_tag   = tag6_ff;
   assign out_mag   = mag6_ff;

endmodule

### sv/tun_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_scale: block normalization and sum of squares
// Five stages: largest magnitude, its bit length, shift to 31 bits,
// squares, sum.
// ----------------------------------------------------------------------------
module tun_scale #(
   parameter int MagWidth = 2 * tun_pkg::COORD_WIDTH_DEF + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  tun_pkg::tag_type                 in_tag,
   input  logic [MagWidth-1:0]              in_mag [3],
   output logic                             out_valid,
   output tun_pkg::tag_type                 out_tag,
   output logic [tun_pkg::NORM_BITS-1:0]    out_norm [3],
   output logic [tun_pkg::SUM_WIDTH-1:0]    out_sum
);
   import tun_pkg::*;

   localparam int LW = $clog2(MagWidth + 1);

   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   tag_type               tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff;
   logic [MagWidth-1:0]   mx1_in, mx1_ff;
   logic [MagWidth-1:0]   mag1_ff [3], mag2_ff [3];
   logic [LW-1:0]         bl2_in, bl2_ff;
   logic [MagWidth-1:0]   sh3 [3];
   logic [NORM_BITS-1:0]  m3_ff [3], m4_ff [3], m5_ff [3];
   logic [SQ_WIDTH-1:0]   sq4_ff [3];
   logic [SUM_WIDTH-1:0]  sum5_ff;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stage 1: largest magnitude
   always_comb begin
      mx1_in = in_mag[0];
      if (in_mag[1] > mx1_in) mx1_in = in_mag[1];
      if (in_mag[2] > mx1_in) mx1_in = in_mag[2];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx1_ff  <= mx1_in;
         mag1_ff <= in_mag;
         tag1_ff <= in_tag;
      end
   end

   // stage 2: bit length of the largest magnitude
   always_comb begin
      bl2_in = '0;
      for (int i = 0; i < MagWidth; i++)
         if (mx1_ff[i]) bl2_in = LW'(i + 1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bl2_ff  <= bl2_in;
         mag2_ff <= mag1_ff;
         tag2_ff <= tag1_ff;
      end
   end

   // stage 3: shift so the largest magnitude has 31 bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (bl2_ff > LW'(NORM_BITS))
            sh3[i] = mag2_ff[i] >> (bl2_ff - LW'(NORM_BITS));
         else
            sh3[i] = mag2_ff[i] << (LW'(NORM_BITS) - bl2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            m3_ff[i] <= sh3[i][NORM_BITS-1:0];
         tag3_ff <= tag2_ff;
      end
   end

   // stage 4: squares
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++)
            sq4_ff[i] <= m3_ff[i] * m3_ff[i];
         m4_ff   <= m3_ff;
         tag4_ff <= tag3_ff;
      end
   end

   // stage 5: sum of squares
   always_ff @(posedge clock) begin
      if (en) begin
         sum5_ff <= SUM_WIDTH'(sq4_ff[0]) + SUM_WIDTH'(sq4_ff[1])
                    + SUM_WIDTH'(sq4_ff[2]);
         m5_ff   <= m4_ff;
         tag5_ff <= tag4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_tag   = tag5_ff;
   assign out_norm  = m5_ff;
   assign out_sum   = sum5_ff;

endmodule

### sv/tun_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_sqrt: pipelined integer square root
// One result bit per stage, 32 stages, floor(sqrt) of a 64-bit value.
// ----------------------------------------------------------------------------
module tun_sqrt #(
   parameter int SideWidth = tun_pkg::TAG_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [tun_pkg::SUM_WIDTH-1:0]    in_sum,
   input  logic [SideWidth-1:0]             in_side,
   output logic                             out_valid,
   output logic [tun_pkg::ROOT_WIDTH-1:0]   out_root,
   output logic [SideWidth-1:0]             out_side
);
   import tun_pkg::*;

   logic [SUM_WIDTH-1:0]  n_src [SQRT_STEPS];
   logic [SUM_WIDTH-1:0]  r_src [SQRT_STEPS];
   logic                  v_src [SQRT_STEPS];
   logic [SideWidth-1:0]  s_src [SQRT_STEPS];
   logic [SUM_WIDTH-1:0]  n_in  [SQRT_STEPS];
   logic [SUM_WIDTH-1:0]  r_in  [SQRT_STEPS];
   logic [SUM_WIDTH-1:0]  n_ff  [SQRT_STEPS];
   logic [SUM_WIDTH-1:0]  r_ff  [SQRT_STEPS];
   logic                  v_ff  [SQRT_STEPS];
   logic [SideWidth-1:0]  s_ff  [SQRT_STEPS];

   // stage inputs
   assign n_src[0] = in_sum;
   assign r_src[0] = '0;
   assign v_src[0] = in_valid;
   assign s_src[0] = in_side;

   for (genvar gk = 1; gk < SQRT_STEPS; gk++) begin : g_link
      assign n_src[gk] = n_ff[gk-1];
      assign r_src[gk] = r_ff[gk-1];
      assign v_src[gk] = v_ff[gk-1];
      assign s_src[gk] = s_ff[gk-1];
   end

   // one trial subtraction per stage
   always_comb begin
      logic [SUM_WIDTH-1:0] bit_k;
      logic [SUM_WIDTH-1:0] trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         bit_k = SUM_WIDTH'(1) << (SUM_WIDTH - 2 - 2 * k);
         trial = r_src[k] + bit_k;
         if (n_src[k] >= trial) begin
            n_in[k] = n_src[k] - trial;
            r_in[k] = (r_src[k] >> 1) + bit_k;
         end else begin
            n_in[k] = n_src[k];
            r_in[k] = r_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STEPS; k++)
            v_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < SQRT_STEPS; k++)
            v_ff[k] <= v_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            n_ff[k] <= n_in[k];
            r_ff[k] <= r_in[k];
            s_ff[k] <= s_src[k];
         end
      end
   end

   assign out_valid = v_ff[SQRT_STEPS-1];
   assign out_root  = r_ff[SQRT_STEPS-1][ROOT_WIDTH-1:0];
   assign out_side  = s_ff[SQRT_STEPS-1];

endmodule

### sv/tun_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_div: three-lane pipelined restoring divider
// Computes (m * 2^30) / len for each lane, one quotient bit per stage,
// 31 stages. The leading quotient bits are known zero since m <= len.
// ----------------------------------------------------------------------------
module tun_div #(
   parameter int SideWidth = tun_pkg::TAG_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [tun_pkg::NORM_BITS-1:0]    in_num [3],
   input  logic [tun_pkg::ROOT_WIDTH-1:0]   in_den,
   input  logic [SideWidth-1:0]             in_side,
   output logic                             out_valid,
   output logic [tun_pkg::QUO_WIDTH-1:0]    out_quo [3],
   output logic [SideWidth-1:0]             out_side
);
   import tun_pkg::*;

   logic [ROOT_WIDTH-1:0] r_src [DIV_STEPS][3];
   logic [QUO_WIDTH-1:0]  q_src [DIV_STEPS][3];
   logic [ROOT_WIDTH-1:0] d_src [DIV_STEPS];
   logic                  v_src [DIV_STEPS];
   logic [SideWidth-1:0]  s_src [DIV_STEPS];
   logic [ROOT_WIDTH-1:0] r_in  [DIV_STEPS][3];
   logic [QUO_WIDTH-1:0]  q_in  [DIV_STEPS][3];
   logic [ROOT_WIDTH-1:0] r_ff  [DIV_STEPS][3];
   logic [QUO_WIDTH-1:0]  q_ff  [DIV_STEPS][3];
   logic [ROOT_WIDTH-1:0] d_ff  [DIV_STEPS];
   logic                  v_ff  [DIV_STEPS];
   logic [SideWidth-1:0]  s_ff  [DIV_STEPS];

   // first stage starts from m >> 1 as partial remainder
   for (genvar gl = 0; gl < 3; gl++) begin : g_init
      assign r_src[0][gl] = {2'b00, in_num[gl][NORM_BITS-1:1]};
      assign q_src[0][gl] = '0;
   end
   assign d_src[0] = in_den;
   assign v_src[0] = in_valid;
   assign s_src[0] = in_side;

   for (genvar gk = 1; gk < DIV_STEPS; gk++) begin : g_link
      assign r_src[gk] = r_ff[gk-1];
      assign q_src[gk] = q_ff[gk-1];
      assign d_src[gk] = d_ff[gk-1];
      assign v_src[gk] = v_ff[gk-1];
      assign s_src[gk] = s_ff[gk-1];
   end

   // shift in the next dividend bit, compare, subtract
   always_comb begin
      logic [ROOT_WIDTH:0] trial;
      logic                nb;
      logic                ge;
      for (int k = 0; k < DIV_STEPS; k++) begin
         for (int l = 0; l < 3; l++) begin
            nb    = (k == 0) ? in_num[l][0] : 1'b0;
            trial = {r_src[k][l], nb};
            ge    = trial >= {1'b0, d_src[k]};
            if (ge)
               r_in[k][l] = ROOT_WIDTH'(trial - {1'b0, d_src[k]});
            else
               r_in[k][l] = trial[ROOT_WIDTH-1:0];
            q_in[k][l] = {q_src[k][l][QUO_WIDTH-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++)
            v_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < DIV_STEPS; k++)
            v_ff[k] <= v_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            r_ff[k] <= r_in[k];
            q_ff[k] <= q_in[k];
            d_ff[k] <= d_src[k];
            s_ff[k] <= s_src[k];
         end
      end
   end

   assign out_valid = v_ff[DIV_STEPS-1];
   assign out_quo   = q_ff[DIV_STEPS-1];
   assign out_side  = s_ff[DIV_STEPS-1];

endmodule

### sv/triangle_unit_normal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_core: unit face normal of a triangle
// Takes three vertices and an optional supplied normal per beat and returns
// the unit normal in Q2.30 with degenerate and used_given flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one triangle per beat (valid/stall). A non-zero supplied
//   normal is normalized as is; otherwise the cross product (b-a)x(c-a) is
//   normalized. A cross product no longer than tiny_length yields a zero
//   vector with rsp_degenerate set.
//   rsp_* returns exactly one beat per accepted request, in order.
//   Throughput: one beat per cycle while not stalled. Pipeline from acceptance
//   to rsp_valid: 6 cross product stages, 5 scaling stages, 32 square root
//   stages, 31 divider stages and the output register.
//   Stall: when a result sits in the output register and rsp_stall is high,
//   the whole pipeline holds and req_stall is raised in the same cycle;
//   nothing is dropped or repeated.
//   Reset (synchronous): empties the pipeline and clears tiny_length to 0.
//   CSR: tiny_length at byte address 0, written through the APB-style port
//   by the user only while the core is idle (not enforced); pready is always high.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core #(
   parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_ax,
   input  logic signed [COORD_WIDTH-1:0]         req_ay,
   input  logic signed [COORD_WIDTH-1:0]         req_az,
   input  logic signed [COORD_WIDTH-1:0]         req_bx,
   input  logic signed [COORD_WIDTH-1:0]         req_by,
   input  logic signed [COORD_WIDTH-1:0]         req_bz,
   input  logic signed [COORD_WIDTH-1:0]         req_cx,
   input  logic signed [COORD_WIDTH-1:0]         req_cy,
   input  logic signed [COORD_WIDTH-1:0]         req_cz,
   input  logic signed [COORD_WIDTH-1:0]         req_given_x,
   input  logic signed [COORD_WIDTH-1:0]         req_given_y,
   input  logic signed [COORD_WIDTH-1:0]         req_given_z,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [tun_pkg::UNIT_WIDTH-1:0] rsp_unit_x,
   output logic signed [tun_pkg::UNIT_WIDTH-1:0] rsp_unit_y,
   output logic signed [tun_pkg::UNIT_WIDTH-1:0] rsp_unit_z,
   output logic                                  rsp_degenerate,
   output logic                                  rsp_used_given,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tun_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [tun_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [tun_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import tun_pkg::*;

   localparam int MW      = 2 * COORD_WIDTH + 1;
   localparam int SQ_SIDE = TAG_WIDTH + 3 * NORM_BITS;

   logic                       en;
   logic [TINY_WIDTH-1:0]      tiny_ff;
   logic                       csr_hit;
   logic signed [COORD_WIDTH-1:0] coord [12];

   logic                       fr_valid;
   tag_type                    fr_tag;
   logic [MW-1:0]              fr_mag [3];

   logic                       sc_valid;
   tag_type                    sc_tag;
   logic [NORM_BITS-1:0]       sc_norm [3];
   logic [SUM_WIDTH-1:0]       sc_sum;

   logic                       sq_valid;
   logic [ROOT_WIDTH-1:0]      sq_root;
   logic [SQ_SIDE-1:0]         sq_side_in, sq_side_out;
   tag_type                    sq_tag;
   logic [NORM_BITS-1:0]       sq_norm [3];
   logic [ROOT_WIDTH-1:0]      sq_den;

   logic                       dv_valid;
   logic [QUO_WIDTH-1:0]       dv_quo [3];
   logic [TAG_WIDTH-1:0]       dv_side;
   tag_type                    dv_tag;
   logic [UNIT_WIDTH-1:0]      unit_in [3];

   logic                       rsp_valid_ff;
   logic [UNIT_WIDTH-1:0]      unit_ff [3];
   logic                       degen_ff, given_ff;

   // configuration register
   assign csr_hit    = csr_paddr[CSR_ADDR_WIDTH-1] == REG_TINY_LENGTH;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_WIDTH'(tiny_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tiny_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         tiny_ff <= csr_pwdata[TINY_WIDTH-1:0];
      end
   end

   // pipeline advances unless a result is held by the receiver
   assign en        = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~en;

   assign coord[0]  = req_ax;
   assign coord[1]  = req_ay;
   assign coord[2]  = req_az;
   assign coord[3]  = req_bx;
   assign coord[4]  = req_by;
   assign coord[5]  = req_bz;
   assign coord[6]  = req_cx;
   assign coord[7]  = req_cy;
   assign coord[8]  = req_cz;
   assign coord[9]  = req_given_x;
   assign coord[10] = req_given_y;
   assign coord[11] = req_given_z;

   tun_front #(.CoordWidth(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .tiny      (tiny_ff),
      .coord     (coord),
      .out_valid (fr_valid),
      .out_tag   (fr_tag),
      .out_mag   (fr_mag)
   );

   tun_scale #(.MagWidth(MW)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_tag    (fr_tag),
      .in_mag    (fr_mag),
      .out_valid (sc_valid),
      .out_tag   (sc_tag),
      .out_norm  (sc_norm),
      .out_sum   (sc_sum)
   );

   assign sq_side_in = {sc_tag, sc_norm[0], sc_norm[1], sc_norm[2]};

   tun_sqrt #(.SideWidth(SQ_SIDE)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sc_valid),
      .in_sum    (sc_sum),
      .in_side   (sq_side_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_out)
   );

   assign {sq_tag, sq_norm[0], sq_norm[1], sq_norm[2]} = sq_side_out;
   // zero length only for a zero vector; keep the divisor nonzero
   assign sq_den = (sq_root == '0) ? ROOT_WIDTH'(1) : sq_root;

   tun_div #(.SideWidth(TAG_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_num    (sq_norm),
      .in_den    (sq_den),
      .in_side   (sq_tag),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   assign dv_tag = dv_side;

   // apply sign, zero a degenerate result
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_tag.degen)
            unit_in[i] = '0;
         else if (dv_tag.neg[i])
            unit_in[i] = -UNIT_WIDTH'(dv_quo[i]);
         else
            unit_in[i] = UNIT_WIDTH'(dv_quo[i]);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff  <= unit_in;
         degen_ff <= dv_tag.degen;
         given_ff <= dv_tag.used_given;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_unit_x     = unit_ff[0];
   assign rsp_unit_y     = unit_ff[1];
   assign rsp_unit_z     = unit_ff[2];
   assign rsp_degenerate = degen_ff;
   assign rsp_used_given = given_ff;

endmodule
